### hw/rtl/wildcard_pattern_matcher_assert.svh
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// same-cycle implication
`define WPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wildcard_pattern_matcher: assertion failed");

// next-cycle implication
`define WPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wildcard_pattern_matcher: assertion failed");

`endif

### hw/rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam logic [7:0] STAR_CHAR = 8'd42;
  localparam logic [7:0] ANY_CHAR  = 8'd63;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TEXT = 1'b1
  } state_t;

  typedef struct packed {
    logic append;
    logic text_start;
    logic step;
    logic report;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic len_zero;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/wpm_ctrl.sv
// ----------------------------------------------------------------------------
// wpm_ctrl
// Sequencer: decodes accepted transactions and walks the pattern cells for
// each text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    op,
  input  wire wpm_pkg::stat_t stat,
  output wpm_pkg::cmd_t      cmd
);

  wpm_pkg::state_t state;
  wpm_pkg::state_t state_next;
  wpm_pkg::op_t    op_code;
  logic            accept;

  assign op_code = wpm_pkg::op_t'(op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wpm_pkg::ST_IDLE: begin
        if (accept && op_code == wpm_pkg::OP_TEXT && !stat.len_zero) begin
          state_next = wpm_pkg::ST_TEXT;
        end
      end
      wpm_pkg::ST_TEXT: begin
        if (stat.last) begin
          state_next = wpm_pkg::ST_IDLE;
        end
      end
      default: state_next = wpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    cmd      = '0;
    unique case (state)
      wpm_pkg::ST_IDLE: begin
        in_stall = (op_code == wpm_pkg::OP_REPORT) && stat.out_busy;
        accept   = in_valid && !in_stall;
        if (accept) begin
          unique case (op_code)
            wpm_pkg::OP_APPEND: cmd.append     = 1'b1;
            wpm_pkg::OP_TEXT:   cmd.text_start = 1'b1;
            wpm_pkg::OP_REPORT: cmd.report     = 1'b1;
            wpm_pkg::OP_CLEAR:  cmd.clear      = 1'b1;
            default:            cmd            = '0;
          endcase
        end
      end
      wpm_pkg::ST_TEXT: begin
        cmd.step = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/wpm_datapath.sv
// ----------------------------------------------------------------------------
// wpm_datapath
// Pattern memory, start and match vectors, cell walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_datapath #(
  parameter int PAT_LEN = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wpm_pkg::cmd_t cmd,
  input  wire logic [7:0]    char_value,
  output wpm_pkg::stat_t     stat,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               matched,
  output logic               overflow
);

  `include "wildcard_pattern_matcher_assert.svh"

  localparam int LW = $clog2(PAT_LEN + 1);
  localparam int AW = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1;

  logic [7:0]     pat_mem [PAT_LEN];
  logic [7:0]     rd_data;
  logic [AW-1:0]  rd_addr;

  logic [LW-1:0]  len;
  logic [LW-1:0]  len_inc;
  logic [LW-1:0]  pos;
  logic [PAT_LEN:0] sv;
  logic [PAT_LEN:0] sv_next;
  logic [PAT_LEN:0] mv;
  logic           ovf;
  logic           full;
  logic [7:0]     txt_char;
  logic           prev;
  logic           old_prev;
  logic           cell_cur;
  logic           cell_next;

  assign full    = (len == LW'(PAT_LEN));
  assign len_inc = len + LW'(1);
  assign rd_addr = cmd.text_start ? '0 : pos[AW-1:0];

  assign stat.last     = (pos == len);
  assign stat.len_zero = (len == '0);
  assign stat.out_busy = out_valid && out_stall;

  // pattern memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      pat_mem[len[AW-1:0]] <= char_value;
    end
    rd_data <= pat_mem[rd_addr];
  end

  always_comb begin
    cell_cur = mv[pos];
    if (rd_data == txt_char || rd_data == wpm_pkg::ANY_CHAR) begin
      cell_next = old_prev;
    end else if (rd_data == wpm_pkg::STAR_CHAR) begin
      cell_next = prev | cell_cur;
    end else begin
      cell_next = 1'b0;
    end
  end

  always_comb begin
    sv_next = sv;
    if (!full) begin
      sv_next[len_inc] = sv[len] && (char_value == wpm_pkg::STAR_CHAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      sv  <= (PAT_LEN + 1)'(1);
      mv  <= (PAT_LEN + 1)'(1);
    end else if (cmd.clear) begin
      len <= '0;
      ovf <= 1'b0;
      sv  <= (PAT_LEN + 1)'(1);
      mv  <= (PAT_LEN + 1)'(1);
    end else if (cmd.append) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        len <= len_inc;
        sv  <= sv_next;
        mv  <= sv_next;
      end
    end else if (cmd.report) begin
      mv <= sv;
    end else if (cmd.text_start) begin
      mv[0] <= 1'b0;
    end else if (cmd.step) begin
      mv[pos] <= cell_next;
    end
  end

  // cell walker: pos is the cell being updated, old_prev the old value of
  // the cell below it, prev the new value of the cell below it
  always_ff @(posedge clk) begin
    if (cmd.text_start) begin
      pos      <= LW'(1);
      prev     <= 1'b0;
      old_prev <= mv[0];
      txt_char <= char_value;
    end else if (cmd.step) begin
      pos      <= pos + LW'(1);
      prev     <= cell_next;
      old_prev <= cell_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      matched  <= mv[len] && !ovf;
      overflow <= ovf;
    end
  end

  `WPM_ASSERT_IMPL(a_ovf_no_match, out_valid && overflow, !matched)
  `WPM_ASSERT_IMPL(a_len_in_range, 1'b1, len <= LW'(PAT_LEN))
  `WPM_ASSERT_IMPL(a_step_in_range, cmd.step, pos != '0 && pos <= len)
  `WPM_ASSERT_NEXT(a_clear_resets, cmd.clear, len == '0 && !ovf && mv == sv)

endmodule

`default_nettype wire

### hw/rtl/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Wildcard matcher: '*' matches any run, '?' any one byte, tracked as a
// bit vector of matching pattern prefixes over a streamed text.
// ----------------------------------------------------------------------------
// Append, report and clear transactions need no cell walk. A text byte is a
// start, then a walk over the cells: the pattern memory has one read port and
// the '*' carry ripples from cell to cell, so the cells are updated one per
// cycle in order; a text byte on an empty pattern has no walk. No input is
// taken while a text byte is being worked. A report is held off while the
// previous result is still stalled at the output; other transactions are not.
// Overflow is sticky until a clear. No clearing pass is needed after reset.
`default_nettype none

module wildcard_pattern_matcher #(
  parameter int PAT_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op,
  input  wire logic [7:0] char_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            matched,
  output logic            overflow
);

  wpm_pkg::cmd_t  cmd;
  wpm_pkg::stat_t stat;

  wpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  wpm_datapath #(
    .PAT_LEN (PAT_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .char_value (char_value),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire
